@@ rtl/link_connect_retry_supervisor_assert.svh @@
// ----------------------------------------------------------------------------
// link_connect_retry_supervisor_assert.svh
// Assertion macros used by the supervisor checker.
// ----------------------------------------------------------------------------
`ifndef LINK_CONNECT_RETRY_SUPERVISOR_ASSERT_SVH
`define LINK_CONNECT_RETRY_SUPERVISOR_ASSERT_SVH

// same-cycle implication
`define LCRS_ASSERT_IMPLY(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lcrs assertion failed");

// next-cycle implication
`define LCRS_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lcrs assertion failed");

`endif

@@ rtl/lcrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcrs_pkg
// Types and constants for the link connect retry supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrs_pkg;

	localparam int TIME_BITS = 32;
	localparam int CMP_W     = (TIME_BITS > 32) ? TIME_BITS : 32;

	localparam logic signed [7:0] RSSI_ABSENT = -8'sd100;
	localparam logic [7:0]        RETRY_MAX   = 8'd255;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_START   = 2'd1,
		MODE_RECONN  = 2'd2,
		MODE_RESET   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_RECONNECT_INTERVAL = 2'd0,
		CFG_CONNECT_TIMEOUT    = 2'd1,
		CFG_MAX_RETRIES        = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [31:0]        now_ms;
		logic               link_up;
		logic signed [7:0]  rssi_dbm;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         state_code;
		logic [7:0]         retry_count;
		logic               start_connect;
		logic               radio_off;
		logic               is_connected;
		logic signed [7:0]  reported_rssi;
	} out_item_t;

	typedef struct packed {
		logic [31:0] reconnect_interval_ms;
		logic [31:0] connect_timeout_ms;
		logic [7:0]  max_retries;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/lcrs_cfg.sv @@
// ----------------------------------------------------------------------------
// lcrs_cfg
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_cfg
	import lcrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reconnect_interval_ms <= 32'd5000;
			cfg_q.connect_timeout_ms    <= 32'd10000;
			cfg_q.max_retries           <= 8'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RECONNECT_INTERVAL: cfg_q.reconnect_interval_ms <= cfg_data;
				CFG_CONNECT_TIMEOUT:    cfg_q.connect_timeout_ms    <= cfg_data;
				CFG_MAX_RETRIES:        cfg_q.max_retries           <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/lcrs_in_stage.sv @@
// ----------------------------------------------------------------------------
// lcrs_in_stage
// Input register; holds one event beat until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_in_stage
	import lcrs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic     take,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	logic     vld_s1;
	in_item_t data_s1;

	assign in_ready = !vld_s1 || take;
	assign valid_s1 = vld_s1;
	assign item_s1  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lcrs_fsm.sv @@
// ----------------------------------------------------------------------------
// lcrs_fsm
// Link state machine, retry counter, attempt timers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_fsm
	import lcrs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     valid_s1,
	input  wire in_item_t item_s1,
	output logic          take,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	typedef enum logic [2:0] {
		S_IDLE         = 3'd0,
		S_CONNECTING   = 3'd1,
		S_CONNECTED    = 3'd2,
		S_DISCONNECTED = 3'd3,
		S_FAILED       = 3'd4
	} state_t;

	typedef logic [TIME_BITS-1:0] time_t;

	state_t    state_q;
	logic [7:0] retries_q;
	time_t     last_q;
	time_t     start_q;
	logic      out_valid_q;
	out_item_t out_q;

	state_t     state_d;
	logic [7:0] retries_d;
	time_t      last_d;
	time_t      start_d;
	logic       start_pulse;
	logic       off_pulse;
	logic       conn;
	logic       advance;

	time_t now_t;
	time_t interval_t;
	time_t back_t;
	time_t el_start;
	time_t el_last;
	logic  timed_out;
	logic  too_soon;

	assign take    = !out_valid_q || out_ready;
	assign advance = valid_s1 && take;

	assign now_t      = TIME_BITS'(item_s1.now_ms);
	assign interval_t = TIME_BITS'(cfg.reconnect_interval_ms);
	assign back_t     = now_t - interval_t;
	assign el_start   = now_t - start_q;
	assign el_last    = now_t - last_q;
	assign timed_out  = CMP_W'(el_start) > CMP_W'(cfg.connect_timeout_ms);
	assign too_soon   = CMP_W'(el_last) < CMP_W'(cfg.reconnect_interval_ms);

	always_comb begin
		state_d     = state_q;
		retries_d   = retries_q;
		last_d      = last_q;
		start_d     = start_q;
		start_pulse = 1'b0;
		off_pulse   = 1'b0;
		case (mode_t'(item_s1.mode))
			MODE_START: begin
				state_d     = S_CONNECTING;
				retries_d   = '0;
				last_d      = now_t;
				start_d     = now_t;
				start_pulse = 1'b1;
			end
			MODE_RECONN: begin
				state_d   = S_DISCONNECTED;
				retries_d = '0;
				last_d    = back_t;
			end
			MODE_RESET: begin
				state_d   = S_IDLE;
				retries_d = '0;
				last_d    = now_t;
				off_pulse = 1'b1;
			end
			MODE_TICK: begin
				if (state_q == S_CONNECTING && item_s1.link_up) begin
					state_d   = S_CONNECTED;
					retries_d = '0;
				end else if (state_q == S_CONNECTED && !item_s1.link_up) begin
					state_d = S_DISCONNECTED;
					last_d  = back_t;
				end else if (state_q == S_CONNECTING) begin
					if (timed_out) begin
						state_d   = S_FAILED;
						retries_d = (retries_q == RETRY_MAX) ? retries_q : retries_q + 8'd1;
						last_d    = now_t;
					end
				end else if (state_q == S_FAILED || state_q == S_DISCONNECTED) begin
					if (!too_soon) begin
						if (retries_q >= cfg.max_retries) begin
							state_d   = S_FAILED;
							retries_d = '0;
							last_d    = now_t;
						end else begin
							state_d     = S_CONNECTING;
							last_d      = now_t;
							start_d     = now_t;
							start_pulse = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		conn = (state_d == S_CONNECTED) && item_s1.link_up;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			retries_q   <= '0;
			last_q      <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				state_q                   <= state_d;
				retries_q                 <= retries_d;
				last_q                    <= last_d;
				start_q                   <= start_d;
				out_q.state_code          <= state_d;
				out_q.retry_count         <= retries_d;
				out_q.start_connect       <= start_pulse;
				out_q.radio_off           <= off_pulse;
				out_q.is_connected        <= conn;
				out_q.reported_rssi       <= conn ? item_s1.rssi_dbm : RSSI_ABSENT;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/link_connect_retry_supervisor.sv @@
// ----------------------------------------------------------------------------
// link_connect_retry_supervisor
// Radio link connect / retry supervisor, one result beat per event beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   event beats (mode, now_ms, link_up, rssi_dbm), valid/ready.
//   out_*  result beats (state, retry count, start/off pulses, rssi), valid/ready.
//   cfg_*  register writes: index 0 reconnect interval, 1 connect timeout,
//          2 max retries; always ready, write only while the block is idle.
// Path: an accepted event lands in the input register, and its result is then
//   loaded into the result register as soon as that register is free.
// Throughput: one event per cycle unless the result stalls; the state update
//   is a single pass of subtract/compare logic from input to result register.
// Stall: while out_ready is low the result holds, one more event waits in
//   the input register, then in_ready drops.
// Reset: state idle, retries and attempt times zero, registers at defaults
//   (5000 ms interval, 10000 ms timeout, 5 retries); no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module link_connect_retry_supervisor
	import lcrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t     cfg;
	logic     take;
	logic     valid_s1;
	in_item_t item_s1;

	lcrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcrs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lcrs_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

@@ rtl/lcrs_checker.sv @@
// ----------------------------------------------------------------------------
// lcrs_checker
// Port-level checks on the supervisor result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_connect_retry_supervisor_assert.svh"

module lcrs_checker
	import lcrs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire out_item_t   out_data
);

	// an off request always leaves the link idle with no retries
	`LCRS_ASSERT_IMPLY(a_off_clears, clk, arst_n, out_valid && out_data.radio_off, out_data.retry_count == 8'd0 && !out_data.is_connected && !out_data.start_connect)

	// rssi is reported only while connected
	`LCRS_ASSERT_IMPLY(a_rssi_absent, clk, arst_n, out_valid && !out_data.is_connected, out_data.reported_rssi == RSSI_ABSENT)

	// a fresh attempt is never reported as already connected
	`LCRS_ASSERT_IMPLY(a_start_not_conn, clk, arst_n, out_valid && out_data.start_connect, !out_data.is_connected)

	// stalled result beat holds
	`LCRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind link_connect_retry_supervisor lcrs_checker u_lcrs_checker (.*);

`default_nettype wire

@@ dv/tb_link_connect_retry_supervisor.sv @@
// ----------------------------------------------------------------------------
// tb_link_connect_retry_supervisor
// Self-checking bench for the link connect / retry supervisor.
// ----------------------------------------------------------------------------
// Event beats come from a queue and go out steadily or in random bursts. The
// receiver stalls on a pattern of its own. Each accepted event runs through a
// local copy of the connect state machine, and the expected status waits in
// order. Each status beat is then checked field by field. Phases run at the
// reset settings, zero interval and timeout, all ones with no retries allowed,
// and small and medium random settings. One phase holds the receiver off long
// enough for the block to back up.
// ----------------------------------------------------------------------------

module tb_link_connect_retry_supervisor;
	import lcrs_pkg::*;

	typedef enum logic [2:0] {
		LS_IDLE         = 3'd0,
		LS_CONNECTING   = 3'd1,
		LS_CONNECTED    = 3'd2,
		LS_DISCONNECTED = 3'd3,
		LS_FAILED       = 3'd4
	} link_st_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	link_connect_retry_supervisor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the supervisor
	logic [31:0] ival_ms      = 32'd5000;
	logic [31:0] tmo_ms       = 32'd10000;
	logic [7:0]  retry_limit  = 8'd5;
	link_st_t    lk_state     = LS_IDLE;
	logic [7:0]  lk_retries   = '0;
	logic [31:0] last_try_ms  = '0;
	logic [31:0] try_start_ms = '0;

	in_item_t    pending_events[$];
	out_item_t   expected_status[$];
	out_item_t   want;
	bit          in_took;
	int          err_count;
	int          beat_count;

	// stimulus generator state
	logic [31:0] gen_ms;
	bit          gen_up;

	// traffic shaping
	bit          tx_steady;
	int          burst_left;
	int          gap_left;
	int          rx_style;
	int          rx_hold_left;
	int unsigned rx_cyc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		if (err_count < 50)
			$display("mismatch at beat %0d: %s got %0h expected %0h", beat_count, what,
				got, exp_val);
		err_count++;
	endtask

	function automatic bit try_connect(logic [31:0] now);
		logic [31:0] gone;
		if (lk_state == LS_IDLE) begin
			lk_state     = LS_CONNECTING;
			try_start_ms = now;
			last_try_ms  = now;
			return 1'b1;
		end
		if (lk_state == LS_CONNECTING) begin
			gone = now - try_start_ms;
			if (gone > tmo_ms) begin
				lk_state = LS_FAILED;
				if (lk_retries != RETRY_MAX)
					lk_retries++;
				last_try_ms = now;
			end
			return 1'b0;
		end
		gone = now - last_try_ms;
		if (gone < ival_ms)
			return 1'b0;
		if (lk_retries >= retry_limit) begin
			// rest period
			lk_state    = LS_FAILED;
			lk_retries  = '0;
			last_try_ms = now;
			return 1'b0;
		end
		lk_state     = LS_CONNECTING;
		try_start_ms = now;
		last_try_ms  = now;
		return 1'b1;
	endfunction

	function automatic out_item_t advance_link(in_item_t ev);
		out_item_t r;
		bit        begun;
		bit        off;
		begun = 1'b0;
		off   = 1'b0;
		case (ev.mode)
			MODE_START: begin
				lk_state    = LS_IDLE;
				lk_retries  = '0;
				last_try_ms = ev.now_ms;
				begun       = try_connect(ev.now_ms);
			end
			MODE_RECONN: begin
				lk_retries  = '0;
				last_try_ms = ev.now_ms - ival_ms;
				lk_state    = LS_DISCONNECTED;
			end
			MODE_RESET: begin
				off         = 1'b1;
				lk_state    = LS_IDLE;
				lk_retries  = '0;
				last_try_ms = ev.now_ms;
			end
			default: begin
				if (lk_state == LS_CONNECTING && ev.link_up) begin
					lk_state   = LS_CONNECTED;
					lk_retries = '0;
				end else if (lk_state == LS_CONNECTED && !ev.link_up) begin
					lk_state    = LS_DISCONNECTED;
					last_try_ms = ev.now_ms - ival_ms;
				end else if (lk_state == LS_FAILED || lk_state == LS_DISCONNECTED ||
						lk_state == LS_CONNECTING) begin
					begun = try_connect(ev.now_ms);
				end
			end
		endcase
		r.state_code    = lk_state;
		r.retry_count   = lk_retries;
		r.start_connect = begun;
		r.radio_off     = off;
		r.is_connected  = (lk_state == LS_CONNECTED) && ev.link_up;
		r.reported_rssi = r.is_connected ? ev.rssi_dbm : RSSI_ABSENT;
		return r;
	endfunction

	// acceptance, prediction and checking
	always @(posedge clk) begin
		in_took = arst_n && in_valid && in_ready;
		if (in_took)
			expected_status.push_back(advance_link(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				note_mismatch("unexpected beat", out_data, '0);
			end else begin
				want = expected_status.pop_front();
				if (out_data.state_code !== want.state_code)
					note_mismatch("state_code", out_data.state_code, want.state_code);
				if (out_data.retry_count !== want.retry_count)
					note_mismatch("retry_count", out_data.retry_count, want.retry_count);
				if (out_data.start_connect !== want.start_connect)
					note_mismatch("start_connect", out_data.start_connect,
						want.start_connect);
				if (out_data.radio_off !== want.radio_off)
					note_mismatch("radio_off", out_data.radio_off, want.radio_off);
				if (out_data.is_connected !== want.is_connected)
					note_mismatch("is_connected", out_data.is_connected, want.is_connected);
				if (out_data.reported_rssi !== want.reported_rssi)
					note_mismatch("reported_rssi", out_data.reported_rssi,
						want.reported_rssi);
			end
			beat_count++;
		end
	end

	// event driver
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				in_data  <= pending_events.pop_front();
				in_valid <= 1'b1;
				if (!tx_steady) begin
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left   = $urandom_range(1, 8);
					end
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// status receiver
	always @(negedge clk) begin
		rx_cyc++;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 9) < 7);
				default: out_ready <= ((rx_cyc % 11) >= 3);
			endcase
		end
	end

	task automatic queue_event(mode_t m, logic [31:0] t, bit up, int rssi);
		in_item_t ev;
		ev.mode     = m;
		ev.now_ms   = t;
		ev.link_up  = up;
		ev.rssi_dbm = 8'(rssi);
		pending_events.push_back(ev);
	endtask

	task automatic queue_random(int n);
		in_item_t    ev;
		int unsigned pick;
		logic [31:0] span;
		repeat (n) begin
			span = (ival_ms > tmo_ms) ? ival_ms : tmo_ms;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				gen_ms += $urandom_range(0, 3);
			else if (pick < 45)
				gen_ms += ival_ms + $urandom_range(0, 2) - 1;
			else if (pick < 60)
				gen_ms += tmo_ms + $urandom_range(0, 2);
			else if (pick < 95)
				gen_ms += $urandom_range(0, (span > 32'd100000) ? 100000 : span + 2);
			else
				gen_ms = $urandom();
			if ($urandom_range(0, 99) < 20)
				gen_up = !gen_up;
			pick = $urandom_range(0, 99);
			if (pick < 80)
				ev.mode = MODE_TICK;
			else if (pick < 88)
				ev.mode = MODE_START;
			else if (pick < 95)
				ev.mode = MODE_RECONN;
			else
				ev.mode = MODE_RESET;
			ev.now_ms   = gen_ms;
			ev.link_up  = gen_up;
			ev.rssi_dbm = 8'(0 - $urandom_range(0, 128));
			pending_events.push_back(ev);
		end
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_events.size() != 0 || in_valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_RECONNECT_INTERVAL: ival_ms = val;
			CFG_CONNECT_TIMEOUT:    tmo_ms = val;
			default:                retry_limit = val[7:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		tx_steady = 1'b0;
		rx_style  = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: walk the state machine, exact thresholds, time wrap
		queue_event(MODE_TICK,   32'd0,     1'b0, -60);
		queue_event(MODE_START,  32'd100,   1'b0, -60);
		queue_event(MODE_TICK,   32'd200,   1'b1, -128);
		queue_event(MODE_TICK,   32'd300,   1'b1, 0);
		queue_event(MODE_TICK,   32'd400,   1'b0, -70);
		queue_event(MODE_TICK,   32'd401,   1'b0, -70);
		queue_event(MODE_TICK,   32'd10401, 1'b0, -70);
		queue_event(MODE_TICK,   32'd10402, 1'b0, -70);
		queue_event(MODE_TICK,   32'd15401, 1'b0, -70);
		queue_event(MODE_TICK,   32'd15402, 1'b0, -70);
		queue_event(MODE_RECONN, 32'd15500, 1'b1, -40);
		queue_event(MODE_RESET,  32'd15600, 1'b1, -40);
		queue_event(MODE_START,  32'hFFFF_FF00, 1'b0, -90);
		queue_event(MODE_TICK,   32'h0000_2800, 1'b0, -90);
		queue_event(MODE_TICK,   32'h0000_2801, 1'b1, -1);
		queue_event(MODE_RESET,  32'hFFFF_FFFF, 1'b1, -1);
		gen_ms = 32'd20000;
		gen_up = 1'b0;
		queue_random(400);
		drain();

		// zero interval and timeout: run the retry count up to saturation
		write_reg(CFG_RECONNECT_INTERVAL, 32'd0);
		write_reg(CFG_CONNECT_TIMEOUT, 32'd0);
		write_reg(CFG_MAX_RETRIES, 32'd255);
		tx_steady = 1'b1;
		rx_style  = 0;
		queue_event(MODE_START, gen_ms, 1'b0, -50);
		repeat (520) begin
			gen_ms += 1;
			queue_event(MODE_TICK, gen_ms, 1'b0, -50);
		end
		queue_random(300);
		drain();

		// all ones, no retries: every attempt past the interval is a rest
		write_reg(CFG_RECONNECT_INTERVAL, 32'hFFFF_FFFF);
		write_reg(CFG_CONNECT_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(CFG_MAX_RETRIES, 32'd0);
		tx_steady = 1'b0;
		rx_style  = 2;
		queue_event(MODE_START,  32'd1000, 1'b0, -80);
		queue_event(MODE_TICK,   32'd1000, 1'b0, -80);
		queue_event(MODE_RECONN, 32'd2000, 1'b0, -80);
		queue_event(MODE_TICK,   32'd2000, 1'b0, -80);
		queue_random(300);
		drain();

		// small settings, receiver held off while the sender keeps pushing
		write_reg(CFG_RECONNECT_INTERVAL, $urandom_range(1, 200));
		write_reg(CFG_CONNECT_TIMEOUT, $urandom_range(1, 300));
		write_reg(CFG_MAX_RETRIES, $urandom_range(1, 6));
		tx_steady    = 1'b1;
		rx_style     = 1;
		rx_hold_left = 400;
		queue_random(400);
		drain();

		// medium settings
		write_reg(CFG_RECONNECT_INTERVAL, $urandom_range(1, 5000));
		write_reg(CFG_CONNECT_TIMEOUT, $urandom_range(1, 5000));
		write_reg(CFG_MAX_RETRIES, $urandom_range(0, 10));
		tx_steady = 1'b0;
		rx_style  = 2;
		queue_random(400);
		drain();

		repeat (10) @(posedge clk);
		if (expected_status.size() != 0)
			note_mismatch("missing beats", '0, expected_status.size());
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lcrs_pkg.sv
rtl/lcrs_cfg.sv
rtl/lcrs_in_stage.sv
rtl/lcrs_fsm.sv
rtl/link_connect_retry_supervisor.sv
rtl/lcrs_checker.sv
dv/tb_link_connect_retry_supervisor.sv
